// ----- hdl/lfid_pkg.sv -----
// Shared types and constants of the lowest-free ID allocator.
package lfid_pkg;

    localparam int ID_W  = 8;
    localparam int ST_W  = 2;
    localparam int CNT_W = 16;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic            valid;
        logic [ID_W-1:0] result_id;
        logic [ST_W-1:0] status;
    } lfid_result_t;

endpackage

// ----- hdl/lfid_req_if.sv -----
// Request channel of the allocator: opcode and the ID to release.
interface lfid_req_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] release_id;

    modport source (output valid, output opcode, output release_id, input ready);
    modport sink   (input valid, input opcode, input release_id, output ready);
endinterface

// ----- hdl/lfid_rsp_if.sv -----
// Response channel of the allocator: the ID and a status code.
interface lfid_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] result_id;
    logic [1:0] status;

    modport source (output valid, output result_id, output status, input ready);
    modport sink   (input valid, input result_id, input status, output ready);
endinterface

// ----- hdl/lfid_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module lfid_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 255
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/lfid_ctrl.sv -----
// Sequencer of the allocator: clearing pass, tree descent and count-chain update.
module lfid_ctrl #(
    parameter int ID_TABLE_SIZE = 255
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    lfid_req_if.sink                              req,
    output lfid_pkg::lfid_result_t                done,
    input  logic                                  done_ack,
    output logic                                  mem_we,
    output logic [$clog2(ID_TABLE_SIZE)-1:0]      mem_waddr,
    output logic [lfid_pkg::CNT_W-1:0]            mem_wdata,
    output logic [$clog2(ID_TABLE_SIZE)-1:0]      mem_raddr,
    input  logic [lfid_pkg::CNT_W-1:0]            mem_rdata
);

    localparam int AW = $clog2(ID_TABLE_SIZE);
    localparam int PW = AW + 1;
    localparam int CW = lfid_pkg::CNT_W;
    localparam int RW = CW + PW;
    localparam logic [PW-1:0] SIZE_P = PW'(ID_TABLE_SIZE);
    localparam logic [AW-1:0] LAST_A = AW'(ID_TABLE_SIZE - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_TOP,
        S_DESC_RD,
        S_DESC_CHK,
        S_CHAIN,
        S_DONE
    } state_t;

    state_t                    state_reg, state_next;
    logic [PW-1:0]             pos_reg, pos_next;
    logic [PW-1:0]             span_reg, span_next;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic [RW-1:0]             right_reg, right_next;
    logic                      oor_reg, oor_next;
    logic                      up_reg, up_next;
    logic [AW-1:0]             clr_reg, clr_next;
    logic [lfid_pkg::ID_W-1:0] res_id_reg, res_id_next;
    logic [lfid_pkg::ST_W-1:0] res_st_reg, res_st_next;

    logic [PW-1:0] new_top;
    logic [PW-1:0] probe;
    logic [CW-1:0] probe_val;
    logic [RW-1:0] right_sum;
    logic [AW-1:0] chain_k;
    logic [AW-1:0] chain_nk;

    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        span_next   = span_reg;
        cnt_next    = cnt_reg;
        right_next  = right_reg;
        oor_next    = oor_reg;
        up_next     = up_reg;
        clr_next    = clr_reg;
        res_id_next = res_id_reg;
        res_st_next = res_st_reg;

        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_raddr = '0;

        new_top   = pos_reg | (pos_reg + PW'(1));
        probe     = pos_reg + span_reg;
        probe_val = oor_reg ? '0 : mem_rdata;
        right_sum = right_reg + RW'(probe_val);
        chain_k   = AW'(pos_reg);
        chain_nk  = chain_k & (chain_k + AW'(1));

        req.ready = (state_reg == S_IDLE);

        done.valid     = (state_reg == S_DONE);
        done.result_id = res_id_reg;
        done.status    = res_st_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                if (clr_reg == LAST_A)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + AW'(1);
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.opcode == lfid_pkg::OP_ALLOC)
                    begin
                        pos_next   = PW'(1);
                        mem_raddr  = AW'(1);
                        state_next = S_TOP;
                    end
                    else
                    begin
                        res_id_next = req.release_id;
                        if (req.release_id == '0
                            || 32'(req.release_id) >= 32'(ID_TABLE_SIZE))
                        begin
                            res_st_next = lfid_pkg::ST_RANGE;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            res_st_next = lfid_pkg::ST_OK;
                            up_next     = 1'b0;
                            pos_next    = PW'(req.release_id);
                            mem_raddr   = AW'(req.release_id);
                            state_next  = S_CHAIN;
                        end
                    end
                end
            end
            S_TOP:
            begin
                // A node whose count equals its span is full: climb to the next top.
                if (RW'(mem_rdata) == RW'(pos_reg) + RW'(1))
                begin
                    if (new_top < SIZE_P)
                    begin
                        pos_next  = new_top;
                        mem_raddr = AW'(new_top);
                    end
                    else
                    begin
                        res_id_next = '0;
                        res_st_next = lfid_pkg::ST_FULL;
                        state_next  = S_DONE;
                    end
                end
                else
                begin
                    cnt_next   = mem_rdata;
                    span_next  = (pos_reg + PW'(1)) >> 1;
                    right_next = '0;
                    state_next = S_DESC_RD;
                end
            end
            S_DESC_RD:
            begin
                if (span_reg == '0)
                begin
                    if (pos_reg >= SIZE_P)
                    begin
                        res_id_next = '0;
                        res_st_next = lfid_pkg::ST_FULL;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        res_id_next = lfid_pkg::ID_W'(pos_reg);
                        res_st_next = lfid_pkg::ST_OK;
                        up_next     = 1'b1;
                        mem_raddr   = AW'(pos_reg);
                        state_next  = S_CHAIN;
                    end
                end
                else
                begin
                    // Nodes beyond the table read as zero.
                    oor_next   = (probe >= SIZE_P);
                    mem_raddr  = (probe >= SIZE_P) ? '0 : AW'(probe);
                    state_next = S_DESC_CHK;
                end
            end
            S_DESC_CHK:
            begin
                // The left half is full when its count covers the right part and the span.
                if (RW'(cnt_reg) == right_sum + RW'(span_reg))
                begin
                    pos_next   = probe;
                    cnt_next   = probe_val;
                    right_next = '0;
                end
                else
                begin
                    right_next = right_sum;
                end
                span_next  = span_reg >> 1;
                state_next = S_DESC_RD;
            end
            S_CHAIN:
            begin
                // Write back this node and read the next one of the chain in the same cycle.
                mem_we    = 1'b1;
                mem_waddr = chain_k;
                mem_wdata = up_reg ? mem_rdata + CW'(1) : mem_rdata - CW'(1);
                if (chain_nk == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    pos_next  = PW'(chain_nk - AW'(1));
                    mem_raddr = chain_nk - AW'(1);
                end
            end
            S_DONE:
            begin
                if (done_ack)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            oor_reg   <= 1'b0;
            up_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            oor_reg   <= oor_next;
            up_reg    <= up_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        span_reg   <= span_next;
        cnt_reg    <= cnt_next;
        right_reg  <= right_next;
        res_id_reg <= res_id_next;
        res_st_reg <= res_st_next;
    end

endmodule

// ----- hdl/lowest_free_id_allocator.sv -----
// Top level of the lowest-free ID allocator: count memory, sequencer and response register.
//
// Usage: each request on the req channel either allocates the lowest free ID
// (opcode 0) or releases release_id (opcode 1). ID 0 is never handed out.
// Every request gives exactly one response on the rsp channel: the allocated
// ID with status 0, ID 0 with status 1 when the table is full, the echoed
// release_id with status 0 after a release, or the echoed release_id with
// status 2 when that ID is 0 or lies beyond the table. Allocation counts live
// in one RAM of ID_TABLE_SIZE 16-bit entries with a registered read port. An
// allocation probes the top nodes, descends the tree, updates the chain of
// covering nodes and hands the response over. A release updates the chain of
// covering nodes and hands the response over; an out-of-range release goes
// straight to the response and leaves the counts alone. The block returns to
// idle before the next request is taken; one request is in work at a time.
// After reset the block runs a clearing pass through every RAM entry and
// holds req.ready low until it is done. A finished response waits in the
// output register while the receiver stalls, and the next request is already
// accepted and worked on in the meantime.
module lowest_free_id_allocator #(
    parameter int ID_TABLE_SIZE = 255
) (
    input  logic      clk,
    input  logic      rst_n,
    lfid_req_if.sink  req,
    lfid_rsp_if.source rsp
);

    localparam int AW = $clog2(ID_TABLE_SIZE);

    lfid_pkg::lfid_result_t done;
    logic                   done_ack;

    logic                       mem_we;
    logic [AW-1:0]              mem_waddr;
    logic [lfid_pkg::CNT_W-1:0] mem_wdata;
    logic [AW-1:0]              mem_raddr;
    logic [lfid_pkg::CNT_W-1:0] mem_rdata;

    logic                       out_valid_reg;
    logic [lfid_pkg::ID_W-1:0]  out_id_reg;
    logic [lfid_pkg::ST_W-1:0]  out_st_reg;

    lfid_ctrl #(
        .ID_TABLE_SIZE (ID_TABLE_SIZE)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .done      (done),
        .done_ack  (done_ack),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    lfid_ram #(
        .WIDTH (lfid_pkg::CNT_W),
        .DEPTH (ID_TABLE_SIZE)
    ) u_counts (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // The output register takes a new response when it is empty or being drained.
    assign done_ack = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done_ack)
        begin
            out_valid_reg <= done.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_ack && done.valid)
        begin
            out_id_reg <= done.result_id;
            out_st_reg <= done.status;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.result_id = out_id_reg;
    assign rsp.status    = out_st_reg;

endmodule

// ----- verif/lfid_grant_checker.sv -----
// Watches both channels of the allocator, predicts every response and compares it.
module lfid_grant_checker #(
    parameter int TABLE_SIZE = 255
) (
    input  logic clk,
    input  logic rst_n,
    lfid_req_if  req,
    lfid_rsp_if  rsp,
    output int   mismatches,
    output int   pending
);

    typedef struct packed {
        logic [lfid_pkg::ID_W-1:0] id;
        logic [lfid_pkg::ST_W-1:0] status;
    } id_grant_t;

    // Shadow copy of the allocation counts; each count wraps at 16 bits.
    logic [lfid_pkg::CNT_W-1:0] id_counts [TABLE_SIZE];
    id_grant_t                  grants_due [$];

    // Nodes past the end of the table read as free.
    function automatic int unsigned node_count(int unsigned k);
        if (k >= TABLE_SIZE)
            return 0;
        return 32'(id_counts[k]);
    endfunction

    // Walk the chain of nodes that cover an ID and move each count by one.
    function automatic void bump_chain(int unsigned id, bit up);
        int unsigned k;
        k = id;
        forever
        begin
            if (up)
                id_counts[k] = id_counts[k] + 1'b1;
            else
                id_counts[k] = id_counts[k] - 1'b1;
            k = k & (k + 1);
            if (k == 0)
                break;
            k = k - 1;
        end
    endfunction

    // Climb the top nodes until one is not full, then descend below it.
    function automatic bit find_free(output int unsigned found);
        int unsigned top_node;
        int unsigned span;
        int unsigned pos;
        int unsigned right;
        top_node = 1;
        found = 0;
        while (top_node < TABLE_SIZE)
        begin
            span = top_node + 1;
            if (node_count(top_node) == span)
            begin
                top_node = top_node | (top_node + 1);
                continue;
            end
            pos = top_node;
            right = 0;
            for (span = span >> 1; span != 0; span = span >> 1)
            begin
                right = right + node_count(pos + span);
                if (node_count(pos) == right + span)
                begin
                    pos = pos + span;
                    right = 0;
                end
            end
            if (pos >= TABLE_SIZE)
                return 1'b0;
            found = pos;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic id_grant_t predict_grant(logic op, logic [lfid_pkg::ID_W-1:0] rel_id);
        id_grant_t   grant;
        int unsigned id;
        if (op == lfid_pkg::OP_ALLOC)
        begin
            if (find_free(id))
            begin
                bump_chain(id, 1'b1);
                grant.id = id[lfid_pkg::ID_W-1:0];
                grant.status = lfid_pkg::ST_OK;
            end
            else
            begin
                grant.id = '0;
                grant.status = lfid_pkg::ST_FULL;
            end
        end
        else
        begin
            grant.id = rel_id;
            if (rel_id == 0 || rel_id >= TABLE_SIZE)
                grant.status = lfid_pkg::ST_RANGE;
            else
            begin
                bump_chain(32'(rel_id), 1'b0);
                grant.status = lfid_pkg::ST_OK;
            end
        end
        return grant;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        id_grant_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_SIZE; i++)
                id_counts[i] = '0;
            grants_due.delete();
            mismatches <= 0;
            pending <= 0;
        end
        else
        begin
            if (req.valid && req.ready)
                grants_due.push_back(predict_grant(req.opcode, req.release_id));
            if (rsp.valid && rsp.ready)
            begin
                if (grants_due.size() == 0)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("[%0t] response with nothing pending: id %0d status %0d",
                                 $realtime, rsp.result_id, rsp.status);
                end
                else
                begin
                    want = grants_due.pop_front();
                    if (rsp.result_id !== want.id || rsp.status !== want.status)
                    begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("[%0t] mismatch: want id %0d status %0d, got id %0d status %0d",
                                     $realtime, want.id, want.status, rsp.result_id,
                                     rsp.status);
                    end
                end
            end
            pending <= grants_due.size();
        end
    end

endmodule

// ----- verif/tb_lowest_free_id_allocator.sv -----
// Testbench top of the lowest-free ID allocator: stimulus, flow control and verdict.
module tb_lowest_free_id_allocator;

    localparam int TABLE_SIZE = 255;

    logic clk = 1'b0;
    logic rst_n;

    lfid_req_if req_ch ();
    lfid_rsp_if rsp_ch ();

    int mismatches;
    int pending;

    // When set, the receiver takes every response at once and the sender
    // leaves no gaps, so that back-to-back traffic is covered as well.
    bit rsp_calm;
    bit req_burst;

    // Opcodes of accepted requests in order, so that a response can be
    // matched to the kind of request that caused it.
    logic          op_log [$];
    // IDs that came back from successful allocations and have not yet been
    // handed back; releases are mostly drawn from here.
    logic [lfid_pkg::ID_W-1:0] held_ids [$];

    lowest_free_id_allocator #(
        .ID_TABLE_SIZE(TABLE_SIZE)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    lfid_grant_checker #(
        .TABLE_SIZE(TABLE_SIZE)
    ) checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .mismatches(mismatches),
        .pending   (pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // The run is cut off here if the block stops answering. The bound is far
    // above the slowest legal run, including the clearing pass after reset.
    initial
    begin
        #20000000;
        $display("DONE: errors detected");
        $finish;
    end

    // Keep track of which allocations succeeded, to feed later releases.
    always @(posedge clk)
    begin
        logic op;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
                op_log.push_back(req_ch.opcode);
            if (rsp_ch.valid && rsp_ch.ready && op_log.size() != 0)
            begin
                op = op_log.pop_front();
                if (op == lfid_pkg::OP_ALLOC && rsp_ch.status == lfid_pkg::ST_OK)
                    held_ids.push_back(rsp_ch.result_id);
            end
        end
    end

    // Gap length: mostly none or short, now and then a long one.
    function automatic int idle_span();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // The receiver alternates between taking responses and stalling, unless
    // rsp_calm is set. A stall is never of zero length, so ready is never lowered
    // and raised within the same step.
    initial
    begin
        int run;
        int stall;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rsp_calm)
            begin
                rsp_ch.ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                run = $urandom_range(1, 12);
                rsp_ch.ready <= 1'b1;
                repeat (run) @(posedge clk);
                stall = idle_span();
                if (stall < 1)
                    stall = 1;
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // Present one request and hold it until the block takes it. The caller
    // arrives just after a rising edge, so the new values land at that edge.
    task automatic send_request(logic op, logic [lfid_pkg::ID_W-1:0] rel_id);
        int gap;
        gap = req_burst ? 0 : idle_span();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.opcode <= op;
        req_ch.release_id <= rel_id;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    task automatic allocate_one();
        // The ID field is ignored here, so it carries random bits.
        send_request(lfid_pkg::OP_ALLOC, lfid_pkg::ID_W'($urandom_range(255)));
    endtask

    // Hand back an ID that is currently held, or allocate if none is known.
    task automatic release_held();
        int idx;
        logic [lfid_pkg::ID_W-1:0] id;
        if (held_ids.size() == 0)
            allocate_one();
        else
        begin
            idx = $urandom_range(held_ids.size() - 1);
            id = held_ids[idx];
            held_ids.delete(idx);
            send_request(lfid_pkg::OP_RELEASE, id);
        end
    endtask

    // Hold off new requests until every predicted response has arrived.
    task automatic drain_responses();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
    endtask

    // One random request. Most are well formed: allocations, and releases of
    // IDs that are really held. A few are releases of ID 0 or of the ID just
    // past the table, which the block must reject and leave the counts alone.
    task automatic random_request(int alloc_pct);
        int r;
        r = $urandom_range(99);
        if (r < alloc_pct)
            allocate_one();
        else if (r < alloc_pct + 5)
            send_request(lfid_pkg::OP_RELEASE,
                         $urandom_range(1) ? lfid_pkg::ID_W'(0)
                                           : lfid_pkg::ID_W'(TABLE_SIZE));
        else
            release_held();
    endtask

    initial
    begin
        int alloc_mix [6];
        int id;

        alloc_mix = '{85, 95, 30, 60, 10, 70};

        rst_n = 1'b0;
        rsp_calm = 1'b0;
        req_burst = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.opcode = lfid_pkg::OP_ALLOC;
        req_ch.release_id = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. The first allocations walk up from the empty table;
        // the ignored ID field is all ones and then all zeros.
        send_request(lfid_pkg::OP_ALLOC, 8'hFF);
        send_request(lfid_pkg::OP_ALLOC, 8'h00);
        repeat (6) allocate_one();
        // ID 0 and the first ID past the table are both out of range.
        send_request(lfid_pkg::OP_RELEASE, 8'h00);
        send_request(lfid_pkg::OP_RELEASE, lfid_pkg::ID_W'(TABLE_SIZE));
        // Wait for all of it to come back, so that the held IDs are known.
        drain_responses();
        release_held();
        release_held();
        allocate_one();
        allocate_one();
        send_request(lfid_pkg::OP_RELEASE, 8'h00);
        allocate_one();

        // Random part in phases with different mixes. The allocation-heavy
        // phases push the table toward full; the release-heavy ones empty it.
        // The third phase runs with no idling on either side.
        for (int p = 0; p < 6; p++)
        begin
            rsp_calm = (p == 2);
            req_burst = (p == 2);
            for (int n = 0; n < 125; n++)
                random_request(alloc_mix[p]);
            if (p == 1)
                drain_responses();
        end
        rsp_calm = 1'b0;
        req_burst = 1'b0;

        // Releases of IDs that may already be free. The block does not check
        // for this and lets the counts wrap, so it comes last: the table is
        // no longer consistent after it. Allocations follow on the damaged
        // counts, and some held IDs are released twice.
        for (int n = 0; n < 10; n++)
        begin
            id = $urandom_range(1, TABLE_SIZE - 1);
            send_request(lfid_pkg::OP_RELEASE, lfid_pkg::ID_W'(id));
        end
        for (int n = 0; n < 4 && held_ids.size() != 0; n++)
        begin
            id = int'(held_ids[0]);
            send_request(lfid_pkg::OP_RELEASE, lfid_pkg::ID_W'(id));
            send_request(lfid_pkg::OP_RELEASE, lfid_pkg::ID_W'(id));
            void'(held_ids.pop_front());
        end
        repeat (10) allocate_one();

        // Let every response out and give the block time to show a stray one.
        rsp_calm = 1'b1;
        drain_responses();
        repeat (100) @(posedge clk);

        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/lfid_pkg.sv
hdl/lfid_req_if.sv
hdl/lfid_rsp_if.sv
hdl/lfid_ram.sv
hdl/lfid_ctrl.sv
hdl/lowest_free_id_allocator.sv
verif/lfid_grant_checker.sv
verif/tb_lowest_free_id_allocator.sv
